@@ rtl/vit_pkg.sv @@
package vit_pkg;

    localparam int ACC_W   = 40;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic               command;
        logic [4:0]         from_label;
        logic [4:0]         to_label;
        logic [4:0]         position;
        logic signed [31:0] score;
        logic               final_position;
    } t_in_word;

    typedef struct packed {
        logic [4:0] label;
        logic [4:0] out_position;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic               is_load;
        logic               lbl_ok;
        logic               decode;
        logic [4:0]         from_label;
        logic [4:0]         to_label;
        logic [4:0]         position;
        logic signed [31:0] score;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACS,
        S_DRAIN,
        S_FIN,
        S_ARG,
        S_TRD,
        S_TWR,
        S_EMIT
    } t_state;

endpackage

@@ rtl/chain_viterbi_decoder_top.sv @@
// Max-sum chain decoder. Both channels behave as queues.
// Input: write a word with push while full is low. command 0 loads one
// transition score (from_label, to_label); command 1 delivers one unary score
// for to_label at the position tagged by position. A unary word with
// final_position set and the top label closes the chain and starts decoding.
// Output: while empty is low the oldest decoded label is on o_out_word; pop
// takes it. One word per position is returned, first position first, last
// flagged on the final one.
// Flow: a load word is written to the table while the engine stays idle. A
// unary word at the first position, or one that neither opens a position nor
// names a valid label, goes straight to FIN; any other passes through ACS and
// DRAIN, run by the single add-compare-select unit that walks the previous
// labels one per cycle. Decoding then runs the best-label search (ARG) and,
// per position after the first, a trace-back read and write (TRD, TWR), then
// one word per cycle while pop is held. The input queue holds four words and
// takes one per cycle while it has room; a stalled receiver holds the result
// and, once the queue fills, raises full. Reset clears queue, scores and chain
// length; the transition table holds until rewritten.
module chain_viterbi_decoder_top #(
    parameter int LBL_N      = 26,
    parameter int MAX_LEN    = 32,
    parameter int SCORE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  vit_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output vit_pkg::t_out_word o_out_word
);

    logic          avail;
    logic          take;
    vit_pkg::t_cmd cmd;

    vit_front #(
        .LBL_N(LBL_N)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_in_word(i_in_word),
        .i_take   (take),
        .o_avail  (avail),
        .o_cmd    (cmd)
    );

    vit_back #(
        .LBL_N     (LBL_N),
        .MAX_LEN   (MAX_LEN),
        .SCORE_BITS(SCORE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (avail),
        .i_cmd     (cmd),
        .o_take    (take),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out_word(o_out_word)
    );

endmodule

@@ rtl/vit_front.sv @@
module vit_front #(
    parameter int LBL_N = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  vit_pkg::t_in_word i_in_word,
    input  logic              i_take,
    output logic              o_avail,
    output vit_pkg::t_cmd     o_cmd
);

    vit_pkg::t_cmd              cmd;
    vit_pkg::t_cmd              r_q [vit_pkg::Q_DEPTH];
    logic [vit_pkg::Q_AW-1:0]   r_wp;
    logic [vit_pkg::Q_AW-1:0]   r_rp;
    logic [vit_pkg::Q_AW:0]     r_cnt;
    logic                       wr;
    logic                       rd;

    always_comb begin
        cmd            = '0;
        cmd.is_load    = !i_in_word.command;
        cmd.from_label = i_in_word.from_label;
        cmd.to_label   = i_in_word.to_label;
        cmd.position   = i_in_word.position;
        cmd.score      = i_in_word.score;
        if (i_in_word.command) begin
            cmd.lbl_ok = {2'b00, i_in_word.to_label} < 7'(LBL_N);
        end else begin
            cmd.lbl_ok = ({2'b00, i_in_word.to_label} < 7'(LBL_N)) &&
                         ({2'b00, i_in_word.from_label} < 7'(LBL_N));
        end
        cmd.decode = i_in_word.command && i_in_word.final_position &&
                     ({2'b00, i_in_word.to_label} == 7'(LBL_N - 1));
    end

    assign o_full  = r_cnt == (vit_pkg::Q_AW + 1)'(vit_pkg::Q_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_cmd   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/vit_back.sv @@
module vit_back #(
    parameter int LBL_N      = 26,
    parameter int MAX_LEN    = 32,
    parameter int SCORE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  vit_pkg::t_cmd      i_cmd,
    output logic               o_take,
    output logic               o_empty,
    input  logic               i_pop,
    output vit_pkg::t_out_word o_out_word
);

    localparam int LW    = $clog2(LBL_N);
    localparam int TT_D  = LBL_N * LBL_N;
    localparam int TT_AW = $clog2(TT_D);
    localparam int BP_D  = MAX_LEN * LBL_N;
    localparam int BP_AW = $clog2(BP_D);
    localparam int CW    = $clog2(MAX_LEN);
    localparam int LENW  = $clog2(MAX_LEN + 1);
    localparam int SW    = (SCORE_BITS < 32) ? SCORE_BITS : 32;
    localparam int AW    = vit_pkg::ACC_W;

    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
        end
        return s[AW-1:0];
    endfunction

    vit_pkg::t_state        r_state;
    vit_pkg::t_state        n_state;

    logic [LENW-1:0]        r_len;
    logic [4:0]             r_tag;
    logic [CW-1:0]          r_cur;
    logic [LW-1:0]          r_to;
    logic signed [SW-1:0]   r_score;
    logic                   r_ok;
    logic                   r_dec;
    logic                   r_clr;
    logic signed [AW-1:0]   r_prev [LBL_N];
    logic signed [AW-1:0]   r_curs [LBL_N];
    logic [LW-1:0]          r_i;
    logic [TT_AW-1:0]       r_addr;
    logic                   r_rd_v;
    logic [LW-1:0]          r_rd_i;
    logic signed [AW-1:0]   r_best;
    logic [LW-1:0]          r_arg;
    logic [CW-1:0]          r_t;
    logic [LW-1:0]          r_nxt;
    logic [LW-1:0]          r_lbl [MAX_LEN];
    logic [CW-1:0]          r_e;

    logic signed [SW-1:0]   tt [TT_D];
    logic signed [SW-1:0]   r_tt_q;
    logic [LW-1:0]          bp [BP_D];
    logic [LW-1:0]          r_bp_q;

    logic                   take;
    logic                   newpos;
    logic                   adv;
    logic [CW-1:0]          cur_idx;
    logic signed [AW-1:0]   acs_sum;
    logic                   arg_upd;
    logic [LW-1:0]          arg_f;
    logic [LW-1:0]          bp_lbl;
    logic [TT_AW-1:0]       tt_waddr;
    logic [BP_AW-1:0]       bp_waddr;
    logic [BP_AW-1:0]       bp_raddr;
    logic                   is_last;
    logic                   out_pop;

    assign take     = (r_state == vit_pkg::S_IDLE) && i_avail;
    assign newpos   = (r_len == '0) || (i_cmd.position != r_tag);
    assign adv      = newpos && (r_len < LENW'(MAX_LEN));
    assign cur_idx  = adv ? CW'(r_len) : CW'(r_len - 1'b1);
    assign acs_sum  = sat_add(r_prev[r_rd_i], AW'(r_tt_q));
    assign arg_upd  = (r_i == '0) || (r_curs[r_i] > r_best);
    assign arg_f    = arg_upd ? r_i : r_arg;
    assign bp_lbl   = (r_state == vit_pkg::S_ACS) ? r_i : r_to;
    assign tt_waddr = TT_AW'(i_cmd.from_label) * TT_AW'(LBL_N) +
                      TT_AW'(i_cmd.to_label);
    assign bp_waddr = BP_AW'(r_cur) * BP_AW'(LBL_N) + BP_AW'(bp_lbl);
    assign bp_raddr = (BP_AW'(r_t) + 1'b1) * BP_AW'(LBL_N) + BP_AW'(r_nxt);
    assign is_last  = r_e == CW'(r_len - 1'b1);
    assign out_pop  = (r_state == vit_pkg::S_EMIT) && i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            vit_pkg::S_IDLE: begin
                if (take && !i_cmd.is_load) begin
                    if ((i_cmd.lbl_ok || adv) && cur_idx != '0) begin
                        n_state = vit_pkg::S_ACS;
                    end else begin
                        n_state = vit_pkg::S_FIN;
                    end
                end
            end
            vit_pkg::S_ACS: begin
                if (r_i == LW'(LBL_N - 1)) begin
                    n_state = vit_pkg::S_DRAIN;
                end
            end
            vit_pkg::S_DRAIN: n_state = vit_pkg::S_FIN;
            vit_pkg::S_FIN:   n_state = r_dec ? vit_pkg::S_ARG : vit_pkg::S_IDLE;
            vit_pkg::S_ARG: begin
                if (r_i == LW'(LBL_N - 1)) begin
                    n_state = (r_len == LENW'(1)) ? vit_pkg::S_EMIT : vit_pkg::S_TRD;
                end
            end
            vit_pkg::S_TRD:   n_state = vit_pkg::S_TWR;
            vit_pkg::S_TWR:   n_state = (r_t == '0) ? vit_pkg::S_EMIT : vit_pkg::S_TRD;
            vit_pkg::S_EMIT: begin
                if (i_pop && is_last) begin
                    n_state = vit_pkg::S_IDLE;
                end
            end
            default: n_state = vit_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_take                  = take;
        o_empty                 = r_state != vit_pkg::S_EMIT;
        o_out_word.label        = 5'(r_lbl[r_e]);
        o_out_word.out_position = 5'(r_e);
        o_out_word.last         = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cmd.is_load && i_cmd.lbl_ok) begin
            tt[tt_waddr] <= i_cmd.score[SW-1:0];
        end
        r_tt_q <= tt[r_addr];
    end

    // clear the back pointers of a fresh position while the ACS walk runs; store the winning label in FIN
    always_ff @(posedge i_clk) begin
        if (r_state == vit_pkg::S_ACS && r_clr) begin
            bp[bp_waddr] <= '0;
        end else if (r_state == vit_pkg::S_FIN && r_ok && r_cur != '0) begin
            bp[bp_waddr] <= r_arg;
        end
        r_bp_q <= bp[bp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur   <= cur_idx;
            r_to    <= LW'(i_cmd.to_label);
            r_score <= i_cmd.score[SW-1:0];
            r_ok    <= i_cmd.lbl_ok;
            r_dec   <= i_cmd.decode;
            r_clr   <= adv;
            r_i     <= '0;
            r_addr  <= TT_AW'(i_cmd.to_label);
        end
        if (r_state == vit_pkg::S_ACS) begin
            r_i    <= r_i + 1'b1;
            r_addr <= r_addr + TT_AW'(LBL_N);
        end
        r_rd_i <= r_i;
        if (r_rd_v && ((r_rd_i == '0) || (acs_sum > r_best))) begin
            r_best <= acs_sum;
            r_arg  <= r_rd_i;
        end
        if (r_state == vit_pkg::S_FIN) begin
            r_i <= '0;
        end
        if (r_state == vit_pkg::S_ARG) begin
            r_i <= r_i + 1'b1;
            if (arg_upd) begin
                r_best <= r_curs[r_i];
                r_arg  <= r_i;
            end
            if (r_i == LW'(LBL_N - 1)) begin
                r_lbl[CW'(r_len - 1'b1)] <= arg_f;
                r_nxt                    <= arg_f;
                r_t                      <= CW'(r_len - LENW'(2));
                r_e                      <= '0;
            end
        end
        if (r_state == vit_pkg::S_TWR) begin
            r_lbl[r_t] <= r_bp_q;
            r_nxt      <= r_bp_q;
            r_t        <= r_t - 1'b1;
            r_e        <= '0;
        end
        if (out_pop) begin
            r_e <= r_e + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vit_pkg::S_IDLE;
            r_len   <= '0;
            r_tag   <= '0;
            r_rd_v  <= 1'b0;
            for (int k = 0; k < LBL_N; k++) begin
                r_prev[k] <= '0;
                r_curs[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rd_v  <= r_state == vit_pkg::S_ACS;
            if (take && !i_cmd.is_load) begin
                r_tag <= i_cmd.position;
                if (adv) begin
                    r_len <= r_len + 1'b1;
                    for (int k = 0; k < LBL_N; k++) begin
                        r_prev[k] <= r_curs[k];
                        r_curs[k] <= '0;
                    end
                end
            end
            if (r_state == vit_pkg::S_FIN && r_ok) begin
                if (r_cur == '0) begin
                    r_curs[r_to] <= AW'(r_score);
                end else begin
                    r_curs[r_to] <= sat_add(r_best, AW'(r_score));
                end
            end
            if (out_pop && is_last) begin
                r_len <= '0;
            end
        end
    end

endmodule

@@ rtl/vit_chk.sv @@
module vit_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input vit_pkg::t_out_word o_out_word
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_out_word))
        else $error("stalled word changed");

    a_position_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_out_word.last) |=>
            !empty && (o_out_word.out_position == $past(o_out_word.out_position) + 5'd1))
        else $error("chain positions not consecutive");

    a_end_of_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_out_word.last) |=> empty)
        else $error("words after last");

endmodule

bind chain_viterbi_decoder_top vit_chk u_vit_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_out_word(o_out_word)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

class vit_scoreboard;
    localparam int NL = 26;
    localparam int ML = 32;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;

    longint             trans[NL*NL];
    longint             prev_s[NL];
    longint             cur_s[NL];
    logic [4:0]         bptr[ML*NL];
    int unsigned        len_seen;
    logic [4:0]         open_tag;
    vit_pkg::t_out_word due_q[$];
    int                 errors;

    function new();
        foreach (trans[i]) trans[i] = 0;
        foreach (prev_s[i]) begin
            prev_s[i] = 0;
            cur_s[i] = 0;
        end
        foreach (bptr[i]) bptr[i] = '0;
        len_seen = 0;
        open_tag = '0;
        errors = 0;
    endfunction

    function longint sat(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function void open_pos();
        if (len_seen >= ML) return;
        prev_s = cur_s;
        foreach (cur_s[i]) cur_s[i] = 0;
        for (int i = 0; i < NL; i++) bptr[len_seen*NL + i] = '0;
        len_seen++;
    endfunction

    function void note_word(vit_pkg::t_in_word w);
        int unsigned cur;
        int unsigned arg;
        int unsigned best;
        longint mx;
        longint v;
        longint sc;
        int lab[ML];
        vit_pkg::t_out_word r;
        sc = longint'(w.score);
        if (w.command == 1'b0) begin
            if (w.from_label < NL && w.to_label < NL)
                trans[w.from_label*NL + w.to_label] = sc;
            return;
        end
        if (len_seen == 0 || w.position != open_tag) open_pos();
        open_tag = w.position;
        cur = len_seen - 1;
        if (w.to_label < NL) begin
            if (cur == 0) begin
                cur_s[w.to_label] = sc;
                bptr[w.to_label] = '0;
            end else begin
                arg = 0;
                mx = sat(prev_s[0] + trans[w.to_label]);
                for (int i = 1; i < NL; i++) begin
                    v = sat(prev_s[i] + trans[i*NL + w.to_label]);
                    if (v > mx) begin
                        mx = v;
                        arg = i;
                    end
                end
                cur_s[w.to_label] = sat(mx + sc);
                bptr[cur*NL + w.to_label] = arg[4:0];
            end
        end
        if (!(w.final_position && w.to_label == NL - 1)) return;
        best = 0;
        for (int i = 1; i < NL; i++)
            if (cur_s[i] > cur_s[best]) best = i;
        lab[len_seen-1] = best;
        for (int t = int'(len_seen) - 2; t >= 0; t--)
            lab[t] = bptr[(t+1)*NL + lab[t+1]];
        for (int i = 0; i < int'(len_seen); i++) begin
            r.label = lab[i][4:0];
            r.out_position = i[4:0];
            r.last = (i == int'(len_seen) - 1);
            due_q = {due_q, r};
        end
        len_seen = 0;
    endfunction

    function void check_word(vit_pkg::t_out_word r);
        vit_pkg::t_out_word e;
        if (due_q.size() == 0) begin
            $display("%0t: unexpected word label=%0d pos=%0d last=%0d",
                     $time, r.label, r.out_position, r.last);
            errors++;
            return;
        end
        e = due_q.pop_front();
        if (r.label !== e.label) begin
            $display("%0t: label exp %0d got %0d", $time, e.label, r.label);
            errors++;
        end
        if (r.out_position !== e.out_position) begin
            $display("%0t: out_position exp %0d got %0d", $time,
                     e.out_position, r.out_position);
            errors++;
        end
        if (r.last !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, r.last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int NL = 26;
    localparam int IDLE_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    vit_pkg::t_in_word  i_in_word = '0;
    logic               empty;
    logic               pop = 1'b0;
    vit_pkg::t_out_word o_out_word;

    vit_scoreboard sb = new();
    bit calm = 1'b0;
    int idle_cycles = 0;
    int sent = 0;
    logic [4:0] tag = '0;

    chain_viterbi_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    function logic signed [31:0] rnd_score();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
        endcase
    endfunction

    // chains use labels 0, 1 and the top label, or labels out of range
    function int live_lbl();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return NL - 1;
            default: return $urandom_range(NL, 31);
        endcase
    endfunction

    function vit_pkg::t_in_word mk(logic cmd, int from, int to, int pos,
                                   logic signed [31:0] sc, logic fin);
        vit_pkg::t_in_word w;
        w.command = cmd;
        w.from_label = from[4:0];
        w.to_label = to[4:0];
        w.position = pos[4:0];
        w.score = sc;
        w.final_position = fin;
        return w;
    endfunction

    task send(vit_pkg::t_in_word w);
        int n;
        n = gap_len();
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
    endtask

    task pause_push();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    // one chain; each position gets a random subset of labels 0, 1, an out-of-range one and the top label
    task run_chain(int len, int density);
        bit fin;
        for (int p = 0; p < len; p++) begin
            tag = tag + 5'd1;
            fin = (p == len - 1);
            for (int l = 0; l < 2; l++)
                if ($urandom_range(0, 99) < density)
                    send(mk(1'b1, $urandom_range(0, 31), l, tag, rnd_score(),
                            fin & $urandom_range(0, 1)));
            if ($urandom_range(0, 99) < density)
                send(mk(1'b1, 0, $urandom_range(NL, 31), tag, rnd_score(), 1'b0));
            if (fin || $urandom_range(0, 2) == 0)
                send(mk(1'b1, $urandom_range(0, 31), NL - 1, tag, rnd_score(), fin));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (push && !full) sb.note_word(i_in_word);
            if (pop && !empty) sb.check_word(o_out_word);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = gap_len();
            if (n > 0) begin
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the columns of the labels that the chains use
        calm = 1'b1;
        for (int f = 0; f < NL; f++) begin
            send(mk(1'b0, f, 0, 0, rnd_score(), 1'b0));
            send(mk(1'b0, f, 1, 0, rnd_score(), 1'b0));
            send(mk(1'b0, f, NL - 1, 0, rnd_score(), 1'b0));
        end
        calm = 1'b0;

        // out-of-range loads are dropped
        send(mk(1'b0, 31, 5, 0, 32'sh7fffffff, 1'b0));
        send(mk(1'b0, 3, 30, 0, 32'sh80000000, 1'b0));
        // single position, top label only
        send(mk(1'b1, 0, NL - 1, 0, 32'sh80000000, 1'b1));
        // all-zero scores: ties go to the lowest label
        for (int t = 0; t < NL; t++) send(mk(1'b0, t, 0, 0, 32'sh0, 1'b0));
        send(mk(1'b1, 0, 0, 7, 32'sh0, 1'b0));
        send(mk(1'b1, 0, 0, 8, 32'sh0, 1'b0));
        // final word on another label only scores, out-of-range label opens position
        send(mk(1'b1, 0, 1, 9, 32'sh7fffffff, 1'b1));
        send(mk(1'b1, 0, 28, 16, 32'sh12345, 1'b0));
        send(mk(1'b1, 0, NL - 1, 31, 32'sh7fffffff, 1'b1));
        // pause until every expected word has come back
        pause_push();
        while (sb.due_q.size() != 0) @(posedge i_clk);

        // over-long chain folds into the last position
        tag = 5'd0;
        calm = 1'b1;
        for (int p = 0; p < 34; p++) begin
            tag = tag + 5'd1;
            send(mk(1'b1, 0, p % 2, tag, rnd_score(), 1'b0));
        end
        send(mk(1'b1, 0, NL - 1, tag, rnd_score(), 1'b1));
        calm = 1'b0;

        while (sent < 205) begin
            case ($urandom_range(0, 9))
                0: send(mk(1'b0, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), rnd_score(), $urandom_range(0, 1)));
                1: begin
                    tag = tag + 5'd1;
                    send(mk(1'b1, $urandom_range(0, 31), live_lbl(), tag,
                            rnd_score(), $urandom_range(0, 1)));
                end
                2: calm = ~calm;
                default: run_chain($urandom_range(1, 6), $urandom_range(20, 60));
            endcase
        end
        run_chain(2, 10);
        push <= 1'b0;

        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
